// File: hdl/mabp_pkg.sv
// Package for the max-abs block pooling block.
// Holds the per-sample tag type, register codes and reset values; no dependencies.
package mabp_pkg;

	localparam int ROW_W = 16;
	localparam int COL_W = 12;
	localparam int OCOL_W = 7;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [12:0] COLS_LIMIT = 13'd4096;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_ROWS_IN    = 3'd0,
		REG_COLS_IN    = 3'd1,
		REG_BLOCK_SIZE = 3'd2,
		REG_OUT_ROWS   = 3'd3,
		REG_OUT_COLS   = 3'd4
	} cfg_reg_t;

	localparam logic [15:0] RST_ROWS_IN    = 16'd1024;
	localparam logic [12:0] RST_COLS_IN    = 13'd1024;
	localparam logic [5:0]  RST_BLOCK_SIZE = 6'd8;
	localparam logic [15:0] RST_OUT_ROWS   = 16'd128;
	localparam logic [7:0]  RST_OUT_COLS   = 8'd128;

	typedef struct packed {
		logic             in_range;
		logic             first_blk;
		logic             first_frame;
		logic             emit;
		logic             frame_last;
		logic [ROW_W-1:0] orow;
		logic [COL_W-1:0] oc;
	} tag_t;

endpackage

// File: hdl/mabp_scan.sv
// Raster position tracking for the max-abs block pooling block.
// Keeps row, column and block counters and tags each sample; uses mabp_pkg.
module mabp_scan import mabp_pkg::*; #(
	parameter int MAX_BLOCK    = 32,
	parameter int MAX_OUT_COLS = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [15:0]      rows_in,
	input  logic [12:0]      cols_in,
	input  logic [5:0]       block_size,
	input  logic [15:0]      out_rows,
	input  logic [7:0]       out_cols,
	output tag_t             tag
);

	localparam int BLK_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [BLK_W-1:0] rib_q;
	logic [BLK_W-1:0] cib_q;
	logic [ROW_W-1:0] orow_q;
	logic [COL_W-1:0] oc_q;

	logic [6:0]       bs7;
	logic [BLK_W-1:0] bs_m1;
	logic [ROW_W-1:0] nr_m1;
	logic [COL_W-1:0] nc_m1;
	logic [COL_W-1:0] oc_lim;
	logic             last_row;
	logic             last_col;
	logic             blk_col_end;
	logic             blk_row_end;

	always_comb begin
		if (block_size == 6'd0) begin
			bs7 = 7'd0;
		end else if ({1'b0, block_size} > 7'(MAX_BLOCK)) begin
			bs7 = 7'(MAX_BLOCK - 1);
		end else begin
			bs7 = {1'b0, block_size} - 7'd1;
		end
		bs_m1 = bs7[BLK_W-1:0];

		nr_m1 = (rows_in == 16'd0) ? 16'd0 : rows_in - 16'd1;

		if (cols_in == 13'd0) begin
			nc_m1 = '0;
		end else if (cols_in > COLS_LIMIT) begin
			nc_m1 = '1;
		end else begin
			nc_m1 = COL_W'(cols_in - 13'd1);
		end

		if ({4'd0, out_cols} > COL_W'(MAX_OUT_COLS)) begin
			oc_lim = COL_W'(MAX_OUT_COLS);
		end else begin
			oc_lim = {4'd0, out_cols};
		end
	end

	assign last_row    = row_q >= nr_m1;
	assign last_col    = col_q >= nc_m1;
	assign blk_col_end = cib_q >= bs_m1;
	assign blk_row_end = rib_q >= bs_m1;

	always_comb begin
		tag.in_range    = (oc_q < oc_lim) && (orow_q < out_rows);
		tag.first_blk   = (rib_q == '0) && (cib_q == '0);
		tag.first_frame = (row_q == '0) && (col_q == '0);
		tag.emit        = tag.in_range && (blk_col_end || last_col) && (blk_row_end || last_row);
		tag.frame_last  = (last_row || orow_q == out_rows - 16'd1)
			&& (last_col || oc_q == oc_lim - COL_W'(1));
		tag.orow        = orow_q;
		tag.oc          = oc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			rib_q  <= '0;
			cib_q  <= '0;
			orow_q <= '0;
			oc_q   <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				cib_q <= '0;
				oc_q  <= '0;
				if (last_row) begin
					row_q  <= '0;
					rib_q  <= '0;
					orow_q <= '0;
				end else begin
					row_q <= row_q + ROW_W'(1);
					if (blk_row_end) begin
						rib_q  <= '0;
						orow_q <= orow_q + ROW_W'(1);
					end else begin
						rib_q <= rib_q + BLK_W'(1);
					end
				end
			end else begin
				col_q <= col_q + COL_W'(1);
				if (blk_col_end) begin
					cib_q <= '0;
					oc_q  <= oc_q + COL_W'(1);
				end else begin
					cib_q <= cib_q + BLK_W'(1);
				end
			end
		end
	end

endmodule

// File: hdl/mabp_pool.sv
// Compare stage, column store and result register of the max-abs pooling block.
// Takes tagged samples from mabp_scan; uses mabp_pkg.
module mabp_pool import mabp_pkg::*; #(
	parameter int SAMPLE_WIDTH = 24,
	parameter int MAX_OUT_COLS = 128
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  tag_t                           tag,
	output logic                           ready,
	output logic                           res_valid,
	input  logic                           res_ready,
	output logic signed [SAMPLE_WIDTH-1:0] block_value,
	output logic [ROW_W-1:0]               out_row,
	output logic [OCOL_W-1:0]              out_col,
	output logic signed [SAMPLE_WIDTH-1:0] running_min,
	output logic signed [SAMPLE_WIDTH-1:0] running_max,
	output logic                           frame_last
);

	localparam int ADDR_W = (MAX_OUT_COLS > 1) ? $clog2(MAX_OUT_COLS) : 1;
	localparam int SW = SAMPLE_WIDTH;

	logic signed [SW-1:0] store_mem [MAX_OUT_COLS];

	logic                 valid_s1_q;
	logic signed [SW-1:0] sample_s1;
	tag_t                 tag_s1;
	logic signed [SW-1:0] rd_s1;

	logic                 byp_valid_q;
	logic [ADDR_W-1:0]    byp_addr_q;
	logic signed [SW-1:0] byp_val_q;

	logic signed [SW-1:0] min_q;
	logic signed [SW-1:0] max_q;
	logic                 res_valid_q;

	logic [ADDR_W-1:0]    addr_in;
	logic [ADDR_W-1:0]    addr_s1;
	logic                 advance;
	logic signed [SW-1:0] prev;
	logic [SW-1:0]        mag_new;
	logic [SW-1:0]        mag_prev;
	logic signed [SW-1:0] best;
	logic signed [SW-1:0] min_base;
	logic signed [SW-1:0] max_base;
	logic signed [SW-1:0] min_new;
	logic signed [SW-1:0] max_new;

	assign addr_in = tag.oc[ADDR_W-1:0];
	assign addr_s1 = tag_s1.oc[ADDR_W-1:0];

	assign advance = valid_s1_q && (!tag_s1.emit || !res_valid_q || res_ready);
	assign ready   = !valid_s1_q || advance;

	always_comb begin
		if (tag_s1.first_blk) begin
			prev = '0;
		end else if (byp_valid_q && byp_addr_q == addr_s1) begin
			prev = byp_val_q;
		end else begin
			prev = rd_s1;
		end
		mag_new  = sample_s1[SW-1] ? -sample_s1 : sample_s1;
		mag_prev = prev[SW-1] ? -prev : prev;
		best     = (mag_new > mag_prev) ? sample_s1 : prev;

		min_base = tag_s1.first_frame ? sample_s1 : min_q;
		max_base = tag_s1.first_frame ? sample_s1 : max_q;
		min_new  = (tag_s1.emit && best < min_base) ? best : min_base;
		max_new  = (tag_s1.emit && best > max_base) ? best : max_base;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= store_mem[addr_in];
		end
	end

	always_ff @(posedge clk) begin
		if (advance && tag_s1.in_range) begin
			store_mem[addr_s1] <= best;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
			tag_s1    <= tag;
		end
		if (advance && tag_s1.in_range) begin
			byp_addr_q <= addr_s1;
			byp_val_q  <= best;
		end
		if (advance && tag_s1.emit) begin
			block_value <= best;
			out_row     <= tag_s1.orow;
			out_col     <= tag_s1.oc[OCOL_W-1:0];
			running_min <= min_new;
			running_max <= max_new;
			frame_last  <= tag_s1.frame_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q  <= 1'b0;
			byp_valid_q <= 1'b0;
			res_valid_q <= 1'b0;
			min_q       <= '0;
			max_q       <= '0;
		end else begin
			if (accept) begin
				valid_s1_q <= 1'b1;
			end else if (advance) begin
				valid_s1_q <= 1'b0;
			end
			if (advance && tag_s1.in_range) begin
				byp_valid_q <= 1'b1;
			end
			if (advance) begin
				min_q <= min_new;
				max_q <= max_new;
			end
			if (advance && tag_s1.emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;

endmodule

// File: hdl/max_abs_block_pooling.sv
// Max-abs block pooling: takes one signed sample per clock in raster order and keeps,
// per square block, the sample of largest magnitude (earliest wins on ties). The
// sustained rate is one sample per clock cycle while no waiting result holds the
// input off. The column store is read when a sample is accepted; the compare, the
// write-back with a bypass of the last write and the load of the result register
// follow as that sample leaves the compare stage. A waiting result with m_tready low
// holds the input off. Write the configuration only while no transaction is in flight.
module max_abs_block_pooling import mabp_pkg::*; #(
	parameter int SAMPLE_WIDTH = 24,
	parameter int MAX_OUT_COLS = 128,
	parameter int MAX_BLOCK    = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// sample
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]        s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// block_value, out_row, out_col, running_min, running_max
	output logic [((3*SAMPLE_WIDTH+23+7)/8)*8-1:0]   m_tdata,
	output logic                  m_tlast,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int OUT_W = ((3 * SAMPLE_WIDTH + 23 + 7) / 8) * 8;

	logic [15:0] rows_in_q;
	logic [12:0] cols_in_q;
	logic [5:0]  block_size_q;
	logic [15:0] out_rows_q;
	logic [7:0]  out_cols_q;

	logic                           accept;
	tag_t                           tag;
	logic signed [SAMPLE_WIDTH-1:0] block_value;
	logic [ROW_W-1:0]               out_row;
	logic [OCOL_W-1:0]              out_col;
	logic signed [SAMPLE_WIDTH-1:0] running_min;
	logic signed [SAMPLE_WIDTH-1:0] running_max;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_in_q    <= RST_ROWS_IN;
			cols_in_q    <= RST_COLS_IN;
			block_size_q <= RST_BLOCK_SIZE;
			out_rows_q   <= RST_OUT_ROWS;
			out_cols_q   <= RST_OUT_COLS;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_ROWS_IN:    rows_in_q    <= cfg_data;
				REG_COLS_IN:    cols_in_q    <= cfg_data[12:0];
				REG_BLOCK_SIZE: block_size_q <= cfg_data[5:0];
				REG_OUT_ROWS:   out_rows_q   <= cfg_data;
				REG_OUT_COLS:   out_cols_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign accept = s_tvalid && s_tready;

	mabp_scan #(
		.MAX_BLOCK    (MAX_BLOCK),
		.MAX_OUT_COLS (MAX_OUT_COLS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.rows_in    (rows_in_q),
		.cols_in    (cols_in_q),
		.block_size (block_size_q),
		.out_rows   (out_rows_q),
		.out_cols   (out_cols_q),
		.tag        (tag)
	);

	mabp_pool #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.MAX_OUT_COLS (MAX_OUT_COLS)
	) u_pool (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.sample      (s_tdata[SAMPLE_WIDTH-1:0]),
		.tag         (tag),
		.ready       (s_tready),
		.res_valid   (m_tvalid),
		.res_ready   (m_tready),
		.block_value (block_value),
		.out_row     (out_row),
		.out_col     (out_col),
		.running_min (running_min),
		.running_max (running_max),
		.frame_last  (m_tlast)
	);

	assign m_tdata = OUT_W'({running_max, running_min, out_col, out_row, block_value});

endmodule
